>>> src/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// shared types and constants of the bilinear texture sampler
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

    localparam int COORD_W = 24;
    localparam int FRAC_W  = 16;
    localparam int DIM_W   = 11;
    localparam int COLOR_W = 8;
    localparam int TEXEL_W = 3 * COLOR_W;
    localparam int CHAN_W  = 16;
    localparam int IDX_W   = 16;
    localparam int ROW_W   = 2 * DIM_W;
    localparam int WT_W    = 2 * FRAC_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          texel_index;
        logic [COLOR_W-1:0]        texel_red;
        logic [COLOR_W-1:0]        texel_green;
        logic [COLOR_W-1:0]        texel_blue;
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
    } req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              size_error;
    } res_t;

    // wrapped coordinates and row offsets handed to the fetch stage
    typedef struct packed {
        logic               valid;
        logic               op;
        logic               err;
        logic               load_ok;
        logic [IDX_W-1:0]   index;
        logic [TEXEL_W-1:0] texel;
        logic [DIM_W-1:0]   u1;
        logic [DIM_W-1:0]   u2;
        logic [FRAC_W-1:0]  fu;
        logic [FRAC_W-1:0]  fv;
        logic [ROW_W-1:0]   row0;
        logic [ROW_W-1:0]   row1;
    } coord_t;

endpackage

`default_nettype wire

>>> src/bts_coord.sv
// ----------------------------------------------------------------------------
// bts_coord
// two-stage coordinate path: scale, repeat wrap, neighbor rows
// ----------------------------------------------------------------------------
`default_nettype none

module bts_coord #(
    parameter int MAX_TEXELS = 65536,
    parameter int MAX_DIM    = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         take,
    input  wire bts_pkg::req_t                req,
    input  wire logic [bts_pkg::DIM_W-1:0]    tex_width,
    input  wire logic [bts_pkg::DIM_W-1:0]    tex_height,
    output bts_pkg::coord_t                   coord
);

    localparam int PROD_W = bts_pkg::FRAC_W + bts_pkg::DIM_W;

    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_op_reg;
    logic                          s1_err_reg;
    logic                          s1_load_ok_reg;
    logic [bts_pkg::IDX_W-1:0]     s1_index_reg;
    logic [bts_pkg::TEXEL_W-1:0]   s1_texel_reg;
    logic [PROD_W-1:0]             s1_pu_reg, s1_pv_reg;
    logic [bts_pkg::ROW_W-1:0]     area;
    logic                          err_next;

    bts_pkg::coord_t               s2_reg, s2_next;
    logic [bts_pkg::DIM_W-1:0]     u1, v1, u2, v2;
    logic [bts_pkg::DIM_W:0]       u1_inc, v1_inc;

    assign s1_valid_next = en ? take : s1_valid_reg;

    always_comb
    begin
        area     = bts_pkg::ROW_W'(tex_width) * bts_pkg::ROW_W'(tex_height);
        err_next = (tex_width == '0) || (tex_height == '0)
                 || (32'(tex_width) > 32'(MAX_DIM)) || (32'(tex_height) > 32'(MAX_DIM))
                 || (32'(area) > 32'(MAX_TEXELS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // only the fraction of the coordinate matters after the repeat wrap
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg      <= req.op;
            s1_err_reg     <= err_next;
            s1_load_ok_reg <= (32'(req.texel_index) < 32'(MAX_TEXELS));
            s1_index_reg   <= req.texel_index;
            s1_texel_reg   <= {req.texel_red, req.texel_green, req.texel_blue};
            s1_pu_reg      <= PROD_W'(req.coord_u[bts_pkg::FRAC_W-1:0]) * PROD_W'(tex_width);
            s1_pv_reg      <= PROD_W'(req.coord_v[bts_pkg::FRAC_W-1:0]) * PROD_W'(tex_height);
        end
    end

    always_comb
    begin
        u1     = s1_pu_reg[PROD_W-1:bts_pkg::FRAC_W];
        v1     = s1_pv_reg[PROD_W-1:bts_pkg::FRAC_W];
        u1_inc = {1'b0, u1} + 1'b1;
        v1_inc = {1'b0, v1} + 1'b1;
        u2     = (u1_inc == {1'b0, tex_width})  ? '0 : u1_inc[bts_pkg::DIM_W-1:0];
        v2     = (v1_inc == {1'b0, tex_height}) ? '0 : v1_inc[bts_pkg::DIM_W-1:0];

        s2_next.valid   = s1_valid_reg;
        s2_next.op      = s1_op_reg;
        s2_next.err     = s1_err_reg;
        s2_next.load_ok = s1_load_ok_reg;
        s2_next.index   = s1_index_reg;
        s2_next.texel   = s1_texel_reg;
        s2_next.u1      = u1;
        s2_next.u2      = u2;
        s2_next.fu      = s1_pu_reg[bts_pkg::FRAC_W-1:0];
        s2_next.fv      = s1_pv_reg[bts_pkg::FRAC_W-1:0];
        s2_next.row0    = bts_pkg::ROW_W'(v1) * bts_pkg::ROW_W'(tex_width);
        s2_next.row1    = bts_pkg::ROW_W'(v2) * bts_pkg::ROW_W'(tex_width);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign coord = s2_reg;

endmodule

`default_nettype wire

>>> src/bts_store.sv
// ----------------------------------------------------------------------------
// bts_store
// texel memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module bts_store #(
    parameter int ADDR_W = 16
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic                          we,
    input  wire logic [ADDR_W-1:0]             waddr,
    input  wire logic [bts_pkg::TEXEL_W-1:0]   wdata,
    input  wire logic [ADDR_W-1:0]             raddr_a,
    input  wire logic [ADDR_W-1:0]             raddr_b,
    output logic      [bts_pkg::TEXEL_W-1:0]   rdata_a,
    output logic      [bts_pkg::TEXEL_W-1:0]   rdata_b
);

    logic [bts_pkg::TEXEL_W-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> src/bts_blend.sv
// ----------------------------------------------------------------------------
// bts_blend
// bilinear weights, per-texel products and the final channel sums
// ----------------------------------------------------------------------------
`default_nettype none

module bts_blend (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          take,
    input  wire logic                          err,
    input  wire logic [bts_pkg::FRAC_W-1:0]    fu,
    input  wire logic [bts_pkg::FRAC_W-1:0]    fv,
    input  wire logic [bts_pkg::TEXEL_W-1:0]   c0,
    input  wire logic [bts_pkg::TEXEL_W-1:0]   c1,
    input  wire logic [bts_pkg::TEXEL_W-1:0]   c2,
    input  wire logic [bts_pkg::TEXEL_W-1:0]   c3,
    output logic                               res_valid,
    output bts_pkg::res_t                      res
);

    localparam int PR_W  = bts_pkg::WT_W + bts_pkg::COLOR_W;
    localparam int SUM_W = PR_W + 2;
    localparam int SH    = 2 * bts_pkg::FRAC_W - bts_pkg::COLOR_W;

    logic                          s3_valid_reg, s3_err_reg;
    logic [bts_pkg::WT_W-1:0]      wt_reg [4];
    logic [bts_pkg::WT_W-1:0]      wt_next [4];
    logic [bts_pkg::FRAC_W:0]      fu_c, fv_c, fu_e, fv_e;

    logic                          s4_valid_reg, s4_err_reg;
    logic [PR_W-1:0]               prod_reg [3][4];
    logic [PR_W-1:0]               prod_next [3][4];
    logic [bts_pkg::TEXEL_W-1:0]   tex [4];

    logic                          res_valid_reg;
    bts_pkg::res_t                 res_reg, res_next;
    logic [SUM_W-1:0]              sum [3];

    always_comb
    begin
        fu_e = {1'b0, fu};
        fv_e = {1'b0, fv};
        fu_c = {1'b1, {bts_pkg::FRAC_W{1'b0}}} - fu_e;
        fv_c = {1'b1, {bts_pkg::FRAC_W{1'b0}}} - fv_e;
        wt_next[0] = bts_pkg::WT_W'(fu_c) * bts_pkg::WT_W'(fv_c);
        wt_next[1] = bts_pkg::WT_W'(fu_e) * bts_pkg::WT_W'(fv_c);
        wt_next[2] = bts_pkg::WT_W'(fu_c) * bts_pkg::WT_W'(fv_e);
        wt_next[3] = bts_pkg::WT_W'(fu_e) * bts_pkg::WT_W'(fv_e);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg  <= take;
            s4_valid_reg  <= s3_valid_reg;
            res_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_err_reg <= err;
            for (int k = 0; k < 4; k++)
            begin
                wt_reg[k] <= wt_next[k];
            end
        end
    end

    // texel data arrives registered together with the weights
    always_comb
    begin
        tex[0] = c0;
        tex[1] = c1;
        tex[2] = c2;
        tex[3] = c3;
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_next[ch][k] = PR_W'(wt_reg[k]) * PR_W'(
                    tex[k][bts_pkg::TEXEL_W-1-ch*bts_pkg::COLOR_W -: bts_pkg::COLOR_W]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_err_reg <= s3_err_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    prod_reg[ch][k] <= prod_next[ch][k];
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = SUM_W'(prod_reg[ch][0]) + SUM_W'(prod_reg[ch][1])
                    + SUM_W'(prod_reg[ch][2]) + SUM_W'(prod_reg[ch][3]);
        end
        res_next.out_red    = s4_err_reg ? '0 : sum[0][SH +: bts_pkg::CHAN_W];
        res_next.out_green  = s4_err_reg ? '0 : sum[1][SH +: bts_pkg::CHAN_W];
        res_next.out_blue   = s4_err_reg ? '0 : sum[2][SH +: bts_pkg::CHAN_W];
        res_next.size_error = s4_err_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> src/bilinear_texture_sampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_top
// bilinear texture sampler with repeat wrap over an on-chip texel store
// ----------------------------------------------------------------------------
// throughput: one request per cycle unless res_stall holds a result; two
// store copies give four reads a cycle; a sample is registered in s1, s2,
// s3, s4 and the result register; loads write the store in order with
// samples, from the s2 register; reset clears the pipeline valids and sets
// both dimensions to 1; store contents are undefined after reset until loaded
`default_nettype none

module bilinear_texture_sampler_top #(
    parameter int MAX_TEXELS = 65536,
    parameter int MAX_DIM    = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire bts_pkg::req_t                   req,
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output bts_pkg::res_t                        res,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bts_pkg::DIM_W-1:0]       cfg_data
);

    localparam int ADDR_W = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
    localparam int SUMA_W = bts_pkg::ROW_W + 1;

    logic                          en;
    logic [bts_pkg::DIM_W-1:0]     tex_width_reg, tex_height_reg;
    bts_pkg::coord_t               coord;
    logic [SUMA_W-1:0]             a0, a1, a2, a3;
    logic                          we;
    logic [bts_pkg::TEXEL_W-1:0]   c0, c1, c2, c3;

    // the whole pipeline moves unless a finished result is held
    assign en        = !res_valid || !res_stall;
    assign req_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= bts_pkg::DIM_W'(1);
            tex_height_reg <= bts_pkg::DIM_W'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == bts_pkg::CFG_TEX_WIDTH)
            begin
                tex_width_reg <= cfg_data;
            end
            if (cfg_index == bts_pkg::CFG_TEX_HEIGHT)
            begin
                tex_height_reg <= cfg_data;
            end
        end
    end

    bts_coord #(
        .MAX_TEXELS (MAX_TEXELS),
        .MAX_DIM    (MAX_DIM)
    ) u_coord (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .take       (req_valid),
        .req        (req),
        .tex_width  (tex_width_reg),
        .tex_height (tex_height_reg),
        .coord      (coord)
    );

    always_comb
    begin
        a0 = SUMA_W'(coord.u1) + SUMA_W'(coord.row0);
        a1 = SUMA_W'(coord.u2) + SUMA_W'(coord.row0);
        a2 = SUMA_W'(coord.u1) + SUMA_W'(coord.row1);
        a3 = SUMA_W'(coord.u2) + SUMA_W'(coord.row1);
        we = coord.valid && (coord.op == bts_pkg::OP_LOAD) && coord.load_ok;
    end

    // two identical copies, each serving two of the four neighbors
    bts_store #(
        .ADDR_W (ADDR_W)
    ) u_store_top (
        .clk     (clk),
        .en      (en),
        .we      (we),
        .waddr   (ADDR_W'(coord.index)),
        .wdata   (coord.texel),
        .raddr_a (a0[ADDR_W-1:0]),
        .raddr_b (a1[ADDR_W-1:0]),
        .rdata_a (c0),
        .rdata_b (c1)
    );

    bts_store #(
        .ADDR_W (ADDR_W)
    ) u_store_bot (
        .clk     (clk),
        .en      (en),
        .we      (we),
        .waddr   (ADDR_W'(coord.index)),
        .wdata   (coord.texel),
        .raddr_a (a2[ADDR_W-1:0]),
        .raddr_b (a3[ADDR_W-1:0]),
        .rdata_a (c2),
        .rdata_b (c3)
    );

    bts_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .take      (coord.valid && (coord.op == bts_pkg::OP_SAMPLE)),
        .err       (coord.err),
        .fu        (coord.fu),
        .fv        (coord.fv),
        .c0        (c0),
        .c1        (c1),
        .c2        (c2),
        .c3        (c3),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

`default_nettype wire
